[rtl/core/vrp_pkg.sv]
package vrp_pkg;

    localparam int TRIG_W     = 16;
    localparam int TRIG_FRAC  = 14;
    localparam int SIZE_W     = 15;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_ROT_X     = 3'd0,
        CFG_ROT_Y     = 3'd1,
        CFG_ROT_Z     = 3'd2,
        CFG_CUBE_SIZE = 3'd3,
        CFG_CENTER_X  = 3'd4,
        CFG_CENTER_Y  = 3'd5
    } t_cfg_idx;

    localparam logic [CFG_DATA_W-1:0] ROT_RESET  = 32'h4000_0000;
    localparam logic [SIZE_W-1:0]     SIZE_RESET = 15'd1600;

endpackage

[rtl/core/vrp_rotate.sv]
// One axis rotation: multiply by Q2.14 cos and sin, then sum and round half up to the scale of i_a and i_b.
module vrp_rotate #(
    parameter int AW = 16,
    parameter int SW = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_vld,
    input  logic signed [AW-1:0]            i_a,
    input  logic signed [AW-1:0]            i_b,
    input  logic signed [vrp_pkg::TRIG_W-1:0] i_cos,
    input  logic signed [vrp_pkg::TRIG_W-1:0] i_sin,
    input  logic [SW-1:0]                   i_side,
    output logic                            o_vld,
    output logic signed [AW+2:0]            o_ac_bs,
    output logic signed [AW+2:0]            o_as_bc,
    output logic [SW-1:0]                   o_side
);

    localparam int PW   = AW + vrp_pkg::TRIG_W;
    localparam int SUMW = PW + 1;
    localparam logic signed [SUMW-1:0] RND = SUMW'(1) << (vrp_pkg::TRIG_FRAC - 1);

    logic                 r_vld_m;
    logic signed [PW-1:0] r_ac, r_bs, r_as, r_bc;
    logic [SW-1:0]        r_side_m;
    logic                 r_vld_o;
    logic signed [AW+2:0] r_ac_bs, r_as_bc;
    logic [SW-1:0]        r_side_o;

    logic signed [PW-1:0]   n_ac, n_bs, n_as, n_bc;
    logic signed [SUMW-1:0] n_sum_d, n_sum_e;

    assign n_ac = i_a * i_cos;
    assign n_bs = i_b * i_sin;
    assign n_as = i_a * i_sin;
    assign n_bc = i_b * i_cos;

    assign n_sum_d = SUMW'(r_ac) - SUMW'(r_bs) + RND;
    assign n_sum_e = SUMW'(r_as) + SUMW'(r_bc) + RND;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_m <= 1'b0;
            r_vld_o <= 1'b0;
        end else if (i_en) begin
            r_vld_m <= i_vld;
            r_vld_o <= r_vld_m;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ac     <= n_ac;
            r_bs     <= n_bs;
            r_as     <= n_as;
            r_bc     <= n_bc;
            r_side_m <= i_side;
            // upper bits of the rounded sum are the floor shift
            r_ac_bs  <= n_sum_d[SUMW-1:vrp_pkg::TRIG_FRAC];
            r_as_bc  <= n_sum_e[SUMW-1:vrp_pkg::TRIG_FRAC];
            r_side_o <= r_side_m;
        end
    end

    assign o_vld   = r_vld_o;
    assign o_ac_bs = r_ac_bs;
    assign o_as_bc = r_as_bc;
    assign o_side  = r_side_o;

    a_stall_holds_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_vld_m) && $stable(r_vld_o))
        else $error("rotate stage valid moved during stall");

endmodule

[rtl/core/vrp_div_step.sv]
// One restoring division step for both coordinates: sets quotient bit SHIFT.
module vrp_div_step #(
    parameter int NW    = 48,
    parameter int DW    = 24,
    parameter int QW    = 18,
    parameter int SHIFT = 0,
    parameter int SW    = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [NW-1:0] i_rem_x,
    input  logic [NW-1:0] i_rem_y,
    input  logic [QW-1:0] i_q_x,
    input  logic [QW-1:0] i_q_y,
    input  logic [DW-1:0] i_d,
    input  logic [SW-1:0] i_side,
    output logic          o_vld,
    output logic [NW-1:0] o_rem_x,
    output logic [NW-1:0] o_rem_y,
    output logic [QW-1:0] o_q_x,
    output logic [QW-1:0] o_q_y,
    output logic [DW-1:0] o_d,
    output logic [SW-1:0] o_side
);

    localparam int CW = ((NW > DW + SHIFT) ? NW : DW + SHIFT) + 1;

    logic [CW-1:0] trial, rem_x_ext, rem_y_ext;
    logic          ge_x, ge_y;
    logic [NW-1:0] n_rem_x, n_rem_y;
    logic [QW-1:0] n_q_x, n_q_y;

    logic          r_vld;
    logic [NW-1:0] r_rem_x, r_rem_y;
    logic [QW-1:0] r_q_x, r_q_y;
    logic [DW-1:0] r_d;
    logic [SW-1:0] r_side;

    always_comb begin
        trial     = CW'(i_d) << SHIFT;
        rem_x_ext = CW'(i_rem_x);
        rem_y_ext = CW'(i_rem_y);
        ge_x      = rem_x_ext >= trial;
        ge_y      = rem_y_ext >= trial;
        n_rem_x   = ge_x ? NW'(rem_x_ext - trial) : i_rem_x;
        n_rem_y   = ge_y ? NW'(rem_y_ext - trial) : i_rem_y;
        n_q_x        = i_q_x;
        n_q_y        = i_q_y;
        n_q_x[SHIFT] = ge_x;
        n_q_y[SHIFT] = ge_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem_x <= n_rem_x;
            r_rem_y <= n_rem_y;
            r_q_x   <= n_q_x;
            r_q_y   <= n_q_y;
            r_d     <= i_d;
            r_side  <= i_side;
        end
    end

    assign o_vld   = r_vld;
    assign o_rem_x = r_rem_x;
    assign o_rem_y = r_rem_y;
    assign o_q_x   = r_q_x;
    assign o_q_y   = r_q_y;
    assign o_d     = r_d;
    assign o_side  = r_side;

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_vld) && $stable(r_q_x) && $stable(r_q_y))
        else $error("divider stage moved during stall");

endmodule

[rtl/core/vertex_rotate_project.sv]
// Pipeline from input accept to result valid:
//   three rotations of two stages each, two projection stages, COORD_WIDTH + 2
//   restoring division steps and one saturating output register.
// Throughput: one item per cycle; the whole pipeline holds while the output is stalled.
// Reset: synchronous active low; clears valid bits and loads register defaults.
module vertex_rotate_project #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [vrp_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [vrp_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // vertex_x, vertex_y, vertex_z
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] i_s_tdata,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // screen_x, screen_y
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0] o_m_tdata,
    // behind_viewer
    output logic                              o_m_tuser
);

    localparam int W   = COORD_WIDTH;
    localparam int OW  = ((2*W+7)/8)*8;
    localparam int R1W = W + 3;
    localparam int R2W = W + 6;
    localparam int R3W = W + 9;
    localparam int DW  = R2W + 2;
    localparam int PXW = R3W + vrp_pkg::SIZE_W + 1;
    localparam int NW  = PXW + 2;
    localparam int QW  = W + 2;
    localparam logic signed [W+2:0] SUM_MAX = {4'b0000, {(W-1){1'b1}}};
    localparam logic signed [W+2:0] SUM_MIN = {4'b1111, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] OUT_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] OUT_MIN = {1'b1, {(W-1){1'b0}}};

    // configuration
    logic [vrp_pkg::CFG_DATA_W-1:0] r_rot_x, r_rot_y, r_rot_z;
    logic [vrp_pkg::SIZE_W-1:0]     r_cube_size;
    logic signed [W-1:0]            r_center_x, r_center_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot_x     <= vrp_pkg::ROT_RESET;
            r_rot_y     <= vrp_pkg::ROT_RESET;
            r_rot_z     <= vrp_pkg::ROT_RESET;
            r_cube_size <= vrp_pkg::SIZE_RESET;
            r_center_x  <= '0;
            r_center_y  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                vrp_pkg::CFG_ROT_X:     r_rot_x     <= i_cfg_wdata;
                vrp_pkg::CFG_ROT_Y:     r_rot_y     <= i_cfg_wdata;
                vrp_pkg::CFG_ROT_Z:     r_rot_z     <= i_cfg_wdata;
                vrp_pkg::CFG_CUBE_SIZE: r_cube_size <= i_cfg_wdata[vrp_pkg::SIZE_W-1:0];
                vrp_pkg::CFG_CENTER_X:  r_center_x  <= i_cfg_wdata[W-1:0];
                vrp_pkg::CFG_CENTER_Y:  r_center_y  <= i_cfg_wdata[W-1:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic r_out_vld;
    assign en         = !r_out_vld || i_m_tready;
    assign o_s_tready = en;

    // rotation about X: (y, z), carry x
    logic                 vld_x;
    logic signed [R1W-1:0] y1, z1;
    logic [W-1:0]         vx_d;

    vrp_rotate #(.AW(W), .SW(W)) u_rot_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(i_s_tvalid),
        .i_a(i_s_tdata[2*W-1:W]), .i_b(i_s_tdata[3*W-1:2*W]),
        .i_cos(r_rot_x[31:16]), .i_sin(r_rot_x[15:0]),
        .i_side(i_s_tdata[W-1:0]),
        .o_vld(vld_x), .o_ac_bs(y1), .o_as_bc(z1), .o_side(vx_d)
    );

    // rotation about Y: a = z1, b = x; carry y1
    logic                  vld_y;
    logic signed [R2W-1:0] z2, x2;
    logic [R1W-1:0]        y1_d;
    logic signed [R1W-1:0] vx_ext;
    assign vx_ext = R1W'($signed(vx_d));

    vrp_rotate #(.AW(R1W), .SW(R1W)) u_rot_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(vld_x),
        .i_a(z1), .i_b(vx_ext),
        .i_cos(r_rot_y[31:16]), .i_sin(r_rot_y[15:0]),
        .i_side(y1),
        .o_vld(vld_y), .o_ac_bs(z2), .o_as_bc(x2), .o_side(y1_d)
    );

    // rotation about Z: a = x2, b = y1; carry z2
    logic                  vld_z;
    logic signed [R3W-1:0] x3, y3;
    logic [R2W-1:0]        z2_d;
    logic signed [R2W-1:0] y1_ext;
    assign y1_ext = R2W'($signed(y1_d));

    vrp_rotate #(.AW(R2W), .SW(R2W)) u_rot_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(vld_y),
        .i_a(x2), .i_b(y1_ext),
        .i_cos(r_rot_z[31:16]), .i_sin(r_rot_z[15:0]),
        .i_side(z2),
        .o_vld(vld_z), .o_ac_bs(x3), .o_as_bc(y3), .o_side(z2_d)
    );

    // projection: denominator and numerator products
    logic signed [DW-1:0]  size_s, n_den, r_den;
    logic signed [vrp_pkg::SIZE_W:0] size_m;
    logic signed [PXW-1:0] r_px, r_py;
    logic                  r_vld_p1;

    assign size_s = DW'($signed({1'b0, r_cube_size}));
    assign size_m = $signed({1'b0, r_cube_size});
    assign n_den  = size_s + (size_s <<< 1) - DW'($signed(z2_d));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_p1 <= 1'b0;
        end else if (en) begin
            r_vld_p1 <= vld_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_den <= n_den;
            r_px  <= x3 * size_m;
            r_py  <= y3 * size_m;
        end
    end

    // floor(n / d) with d > 0: divide ~n when n is negative, then invert
    logic signed [NW-1:0] num_x, num_y;
    logic [NW-1:0]        n_mag_x, n_mag_y;
    logic [DW-1:0]        n_dd;
    logic [2:0]           n_side;

    always_comb begin
        num_x   = (NW'(r_px) <<< 1) + NW'(r_den);
        num_y   = (NW'(r_py) <<< 1) + NW'(r_den);
        n_mag_x = num_x[NW-1] ? ~num_x : num_x;
        n_mag_y = num_y[NW-1] ? ~num_y : num_y;
        n_dd    = {r_den[DW-2:0], 1'b0};
        n_side  = {r_den[DW-1] || (r_den == '0), num_y[NW-1], num_x[NW-1]};
    end

    logic          st_vld  [0:QW];
    logic [NW-1:0] st_rem_x[0:QW];
    logic [NW-1:0] st_rem_y[0:QW];
    logic [QW-1:0] st_q_x  [0:QW];
    logic [QW-1:0] st_q_y  [0:QW];
    logic [DW-1:0] st_d    [0:QW];
    logic [2:0]    st_side [0:QW];

    logic          r_st0_vld;
    logic [NW-1:0] r_st0_rem_x, r_st0_rem_y;
    logic [DW-1:0] r_st0_d;
    logic [2:0]    r_st0_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st0_vld <= 1'b0;
        end else if (en) begin
            r_st0_vld <= r_vld_p1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_st0_rem_x <= n_mag_x;
            r_st0_rem_y <= n_mag_y;
            r_st0_d     <= n_dd;
            r_st0_side  <= n_side;
        end
    end

    assign st_vld[0]   = r_st0_vld;
    assign st_rem_x[0] = r_st0_rem_x;
    assign st_rem_y[0] = r_st0_rem_y;
    assign st_q_x[0]   = '0;
    assign st_q_y[0]   = '0;
    assign st_d[0]     = r_st0_d;
    assign st_side[0]  = r_st0_side;

    // top quotient bit marks a quotient too large for the output range
    for (genvar k = 0; k < QW; k++) begin : g_div
        vrp_div_step #(.NW(NW), .DW(DW), .QW(QW), .SHIFT(QW-1-k), .SW(3)) u_step (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(st_vld[k]),
            .i_rem_x(st_rem_x[k]), .i_rem_y(st_rem_y[k]),
            .i_q_x(st_q_x[k]), .i_q_y(st_q_y[k]),
            .i_d(st_d[k]), .i_side(st_side[k]),
            .o_vld(st_vld[k+1]), .o_rem_x(st_rem_x[k+1]), .o_rem_y(st_rem_y[k+1]),
            .o_q_x(st_q_x[k+1]), .o_q_y(st_q_y[k+1]),
            .o_d(st_d[k+1]), .o_side(st_side[k+1])
        );
    end

    // add center, saturate, zero when behind the viewer
    logic                 behind;
    logic [QW-1:0]        q_x, q_y;
    logic signed [W+1:0]  sq_x, sq_y;
    logic signed [W+2:0]  sum_x, sum_y;
    logic signed [W-1:0]  n_sx, n_sy;

    always_comb begin
        q_x    = st_q_x[QW];
        q_y    = st_q_y[QW];
        behind = st_side[QW][2];
        sq_x   = st_side[QW][0] ? ~{1'b0, q_x[QW-2:0]} : {1'b0, q_x[QW-2:0]};
        sq_y   = st_side[QW][1] ? ~{1'b0, q_y[QW-2:0]} : {1'b0, q_y[QW-2:0]};
        sum_x  = (W+3)'(sq_x) + (W+3)'(r_center_x);
        sum_y  = (W+3)'(sq_y) + (W+3)'(r_center_y);

        if (q_x[QW-1])         n_sx = st_side[QW][0] ? OUT_MIN : OUT_MAX;
        else if (sum_x > SUM_MAX) n_sx = OUT_MAX;
        else if (sum_x < SUM_MIN) n_sx = OUT_MIN;
        else                   n_sx = sum_x[W-1:0];

        if (q_y[QW-1])         n_sy = st_side[QW][1] ? OUT_MIN : OUT_MAX;
        else if (sum_y > SUM_MAX) n_sy = OUT_MAX;
        else if (sum_y < SUM_MIN) n_sy = OUT_MIN;
        else                   n_sy = sum_y[W-1:0];

        if (behind) begin
            n_sx = '0;
            n_sy = '0;
        end
    end

    logic signed [W-1:0] r_sx, r_sy;
    logic                r_behind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= st_vld[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sx     <= n_sx;
            r_sy     <= n_sy;
            r_behind <= behind;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = OW'({r_sy, r_sx});
    assign o_m_tuser  = r_behind;

    a_behind_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> r_sx == '0 && r_sy == '0)
        else $error("behind-viewer item carries nonzero coordinates");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && !st_vld[0])
        else $error("valid survived reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("output item changed while stalled");

endmodule
